// File: hdl/detector_pulse_byte_parser_macros.svh
// ----------------------------------------------------------------------------
// Pulse byte parser assertion macros
// Shared wrappers for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_PULSE_BYTE_PARSER_MACROS_SVH
`define DETECTOR_PULSE_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DPBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DPBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dpbp_pkg.sv
// ----------------------------------------------------------------------------
// Pulse byte parser package
// Phase codes, merge operations and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package dpbp_pkg;

    localparam int PHASE_W = 6;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;

    typedef logic [PHASE_W-1:0] t_phase;

    // Phase codes
    localparam t_phase PH_READY = 6'd0;
    localparam t_phase PH_ERROR = 6'd1;
    localparam t_phase PH_HDR   = 6'd2;
    localparam t_phase PH_HIT   = 6'd18;
    localparam t_phase PH_END   = 6'd34;
    localparam t_phase PH_LAST  = 6'd41;

    // Frame marker bytes
    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFA;
    localparam logic [BYTE_W-1:0] TRL_BYTE   = 8'hFB;
    localparam logic [3:0]        HIT_NIBBLE = 4'hE;

    localparam logic [WORD_W-1:0] FRAME_START = 32'd16;
    localparam logic [WORD_W-1:0] FRAME_STEP  = 32'd4;

    // How a byte merges into the assembled word
    typedef enum logic [3:0] {
        MG_HOLD,
        MG_ZERO,
        MG_LOAD,
        MG_SET24,
        MG_SET16,
        MG_SET8,
        MG_OR16,
        MG_OR8,
        MG_OR0
    } t_merge;

    // How the frame byte tally moves
    typedef enum logic [1:0] {
        FR_HOLD,
        FR_START,
        FR_ADD
    } t_frame_op;

    // Parser state, also the per-byte result
    typedef struct packed {
        t_phase              phase;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   frame;
    } t_state;

endpackage

`default_nettype wire

// File: hdl/dpbp_step.sv
// ----------------------------------------------------------------------------
// Pulse byte parser step
// Next parser state from the current state and one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbp_step
    import dpbp_pkg::*;
(
    input  wire t_state             i_cur,
    input  wire logic [BYTE_W-1:0]  i_byte,
    output t_state                  o_nxt
);

    logic [3:0]        hdr_step;
    logic [3:0]        hit_step;
    logic [2:0]        end_step;
    logic [WORD_W-1:0] byte_ext;
    t_merge            merge;
    t_frame_op         frame_op;
    t_phase            phase_nxt;

    assign hdr_step = 4'(i_cur.phase - PH_HDR);
    assign hit_step = 4'(i_cur.phase - PH_HIT);
    assign end_step = 3'(i_cur.phase - PH_END);
    assign byte_ext = WORD_W'(i_byte);

    // Phase walk and merge selection
    always_comb begin
        merge     = MG_HOLD;
        frame_op  = FR_HOLD;
        phase_nxt = i_cur.phase + 6'd1;
        priority if (i_cur.phase == PH_READY || i_cur.phase == PH_LAST) begin
            phase_nxt = (i_byte == HDR_BYTE) ? PH_HDR : PH_READY;
        end else if (i_cur.phase >= PH_HDR && i_cur.phase < PH_HIT && hdr_step != 4'd15) begin
            unique case (hdr_step)
                4'd7:    merge = MG_SET24;
                4'd8:    merge = MG_OR16;
                4'd9:    merge = MG_OR8;
                4'd10:   merge = MG_OR0;
                4'd11:   merge = MG_SET16;
                4'd12:   merge = MG_OR8;
                4'd13:   merge = MG_OR0;
                4'd14: begin
                    merge    = MG_LOAD;
                    frame_op = FR_START;
                end
                default: merge = MG_LOAD;   // id bytes
            endcase
        end else if ((i_cur.phase >= PH_HDR && i_cur.phase < PH_HIT)
                     || (i_cur.phase >= PH_HIT && i_cur.phase < PH_END && hit_step == 4'd15)) begin
            // record boundary: trailer, new hit or broken frame
            priority if (i_byte == TRL_BYTE) begin
                merge     = MG_ZERO;
                phase_nxt = PH_END;
            end else if (i_byte[7:4] == HIT_NIBBLE) begin
                merge     = MG_LOAD;
                phase_nxt = PH_HIT;
            end else begin
                merge     = MG_LOAD;
                phase_nxt = PH_ERROR;
            end
        end else if (i_cur.phase >= PH_HIT && i_cur.phase < PH_END) begin
            unique case (hit_step)
                4'd0, 4'd4, 4'd8:           merge = MG_OR16;
                4'd1, 4'd5, 4'd9:           merge = MG_OR8;
                4'd3, 4'd7:                 merge = MG_SET24;
                4'd11, 4'd13:               merge = MG_SET8;
                4'd2, 4'd6, 4'd10, 4'd14: begin
                    merge    = MG_OR0;
                    frame_op = FR_ADD;
                end
                default:                    merge = MG_OR0;
            endcase
            // TOF starts fresh in the middle byte lane
            if (hit_step == 4'd0) begin
                merge = MG_SET16;
            end
        end else if (i_cur.phase >= PH_END && i_cur.phase < PH_LAST) begin
            unique case (end_step)
                3'd0:    merge = MG_SET16;
                3'd1:    merge = MG_OR8;
                3'd2: begin
                    merge    = MG_OR0;
                    frame_op = FR_ADD;
                end
                3'd3:    merge = MG_SET24;
                3'd4:    merge = MG_OR16;
                3'd5:    merge = MG_OR8;
                default: merge = MG_OR0;
            endcase
        end else begin
            // error phase and unused codes drop the byte
            phase_nxt = PH_READY;
        end
    end

    // Word merge and frame tally update
    always_comb begin
        o_nxt.phase = phase_nxt;
        unique case (merge)
            MG_ZERO:  o_nxt.word = '0;
            MG_LOAD:  o_nxt.word = byte_ext;
            MG_SET24: o_nxt.word = byte_ext << 24;
            MG_SET16: o_nxt.word = byte_ext << 16;
            MG_SET8:  o_nxt.word = byte_ext << 8;
            MG_OR16:  o_nxt.word = i_cur.word | (byte_ext << 16);
            MG_OR8:   o_nxt.word = i_cur.word | (byte_ext << 8);
            MG_OR0:   o_nxt.word = i_cur.word | byte_ext;
            default:  o_nxt.word = i_cur.word;
        endcase
        unique case (frame_op)
            FR_START: o_nxt.frame = FRAME_START;
            FR_ADD:   o_nxt.frame = i_cur.frame + FRAME_STEP;
            default:  o_nxt.frame = i_cur.frame;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/detector_pulse_byte_parser.sv
// Pipeline: an input transfer is held in the input byte register, then its result in the output register.
// Throughput: one byte per cycle while the master side accepts results; the
// registered state update loop of the parser step sets that rate.
// Reset: synchronous, active low; parser returns to ready, word and tally
// clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// Pulse byte parser
// Walks detector pulse frames one byte at a time and reports the assembled
// field value, phase, error flag and frame byte tally for every byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "detector_pulse_byte_parser_macros.svh"

module detector_pulse_byte_parser
    import dpbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] word_value, [63:32] byte_count
    output logic [6:0]       m_axis_tuser    // [5:0] phase, [6] error
);

    logic               r_in_vld;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_vld;
    logic               r_out_err;
    t_state             r_state;
    t_state             n_state;
    t_state             r_out;
    logic               out_adv;
    logic               step;

    // Output stage frees when empty or drained this cycle
    assign out_adv       = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_adv;
    assign s_axis_tready = !r_in_vld || out_adv;

    dpbp_step u_step (
        .i_cur  (r_state),
        .i_byte (r_in_byte),
        .o_nxt  (n_state)
    );

    // Control: stage valids and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{phase: PH_READY, word: '0, frame: '0};
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (step) begin
                r_state <= n_state;
            end
        end
    end

    // Payload: input byte and result
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_out     <= n_state;
            r_out_err <= (n_state.phase == PH_ERROR);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.frame, r_out.word};
    assign m_axis_tuser  = {r_out_err, r_out.phase};

    // Checks
    `DPBP_ASSERT_NOW(a_phase_range, 1'b1, r_state.phase <= PH_LAST, "phase code out of range")
    `DPBP_ASSERT_NEXT(a_stall_holds_state, m_axis_tvalid && !m_axis_tready,
        $stable(r_state), "parser state moved while result stalled")
    `DPBP_ASSERT_NEXT(a_error_recovers, step && r_state.phase == PH_ERROR,
        r_state.phase == PH_READY, "error phase did not return to ready")
    `DPBP_ASSERT_NEXT(a_tally_steps,
        step && r_state.phase != 6'd16 && r_state.phase != 6'd20
        && r_state.phase != 6'd24 && r_state.phase != 6'd28
        && r_state.phase != 6'd32 && r_state.phase != 6'd36,
        $stable(r_state.frame), "frame tally moved outside a counting byte")

endmodule

`default_nettype wire
